/* hw/rtl/kufm_pkg.sv */
// ----------------------------------------------------------------------------
// Kruskal union-find merger package
// Field widths, register reset value and default forest size shared by the
// interfaces, the controller, the top level and the checker.
// ----------------------------------------------------------------------------
package kufm_pkg;

  localparam int unsigned WEIGHT_W  = 24;
  localparam int unsigned NODE_W    = 10;
  localparam int unsigned NC_W      = 11;
  localparam int unsigned TOTAL_W   = 40;
  localparam int unsigned NODES_DEF = 1024;

  localparam logic [NC_W-1:0] NC_RESET = 11'd1024;

endpackage

/* hw/rtl/kufm_edge_if.sv */
// ----------------------------------------------------------------------------
// Edge channel
// Valid/ready channel that carries one sorted edge per item.
// ----------------------------------------------------------------------------
interface kufm_edge_if;
  import kufm_pkg::*;

  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;

  modport source (output valid, weight, node_a, node_b, input ready);
  modport sink   (input valid, weight, node_a, node_b, output ready);

endinterface

/* hw/rtl/kufm_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one merge result per item.
// ----------------------------------------------------------------------------
interface kufm_result_if;
  import kufm_pkg::*;

  logic               valid;
  logic               ready;
  logic               merged;
  logic [TOTAL_W-1:0] total_weight;
  logic               spanning;

  modport source (output valid, merged, total_weight, spanning, input ready);
  modport sink   (input valid, merged, total_weight, spanning, output ready);

endinterface

/* hw/rtl/kufm_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data. A read of the
// address being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module kufm_ram #(
  parameter  int unsigned DEPTH = 1024,
  parameter  int unsigned WIDTH = 10,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/kufm_ctrl.sv */
// ----------------------------------------------------------------------------
// Union-find sequencer
// Clears both tables after reset, then per in-range edge walks and compresses
// both endpoint paths, merges by size if the roots differ, keeps the saturating
// total and finishes with a spanning find on node_a if it lies below NODES.
// ----------------------------------------------------------------------------
module kufm_ctrl #(
  parameter  int unsigned NODES = kufm_pkg::NODES_DEF,
  localparam int unsigned NW    = $clog2(NODES),
  localparam int unsigned SW    = $clog2(NODES + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [kufm_pkg::NC_W-1:0] node_count_i,
  kufm_edge_if.sink               edge_i,
  kufm_result_if.source           result_o,
  output logic                    p_we_o,
  output logic [NW-1:0]           p_waddr_o,
  output logic [NW-1:0]           p_wdata_o,
  output logic [NW-1:0]           p_raddr_o,
  input  logic [NW-1:0]           p_rdata_i,
  output logic                    s_we_o,
  output logic [NW-1:0]           s_waddr_o,
  output logic [SW-1:0]           s_wdata_o,
  output logic [NW-1:0]           s_raddr_o,
  input  logic [SW-1:0]           s_rdata_i
);
  import kufm_pkg::*;

  localparam int unsigned CW  = (NW + 1 > NC_W) ? NW + 1 : NC_W;
  localparam int unsigned KW  = (SW > NC_W) ? SW : NC_W;
  localparam int unsigned TSW = TOTAL_W + 1;
  localparam logic [NW-1:0] LAST = NW'(NODES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WALK, ST_COMP, ST_SIZE_A, ST_SIZE_B, ST_SPAN, ST_DONE
  } state_e;

  typedef enum logic [1:0] {PH_FIND_A, PH_FIND_B, PH_SPAN} phase_e;

  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [NW-1:0]       cur_q, cur_d;
  logic [NW-1:0]       start_q, start_d;
  logic [NW-1:0]       root_q, root_d;
  logic [NW-1:0]       a_q, a_d;
  logic [NW-1:0]       b_q, b_d;
  logic [NW-1:0]       ra_q, ra_d;
  logic [NW-1:0]       rb_q, rb_d;
  logic [NW-1:0]       clr_q, clr_d;
  logic [SW-1:0]       sa_q, sa_d;
  logic [WEIGHT_W-1:0] w_q, w_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                merged_q, merged_d;
  logic                span_q, span_d;
  logic                res_valid_q, res_valid_d;
  logic                res_merged_q, res_merged_d;
  logic [TOTAL_W-1:0]  res_total_q, res_total_d;
  logic                res_span_q, res_span_d;

  logic                fdone;
  logic [NW-1:0]       froot;
  logic                a_ok;
  logic                pair_ok;
  logic [CW-1:0]       a_ext;
  logic [CW-1:0]       b_ext;
  logic [CW-1:0]       nc_ext;
  logic [NW-1:0]       win;
  logic [NW-1:0]       lose;
  logic [TSW-1:0]      tsum;

  assign a_ext   = CW'(edge_i.node_a);
  assign b_ext   = CW'(edge_i.node_b);
  assign nc_ext  = CW'(node_count_i);
  assign a_ok    = a_ext < CW'(NODES);
  assign pair_ok = a_ok && (b_ext < CW'(NODES)) && (a_ext < nc_ext) && (b_ext < nc_ext);
  assign tsum    = {1'b0, total_q} + TSW'(w_q);

  assign edge_i.ready          = (state_q == ST_IDLE);
  assign result_o.valid        = res_valid_q;
  assign result_o.merged       = res_merged_q;
  assign result_o.total_weight = res_total_q;
  assign result_o.spanning     = res_span_q;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    cur_d        = cur_q;
    start_d      = start_q;
    root_d       = root_q;
    a_d          = a_q;
    b_d          = b_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    clr_d        = clr_q;
    sa_d         = sa_q;
    w_d          = w_q;
    total_d      = total_q;
    merged_d     = merged_q;
    span_d       = span_q;
    res_valid_d  = res_valid_q && !result_o.ready;
    res_merged_d = res_merged_q;
    res_total_d  = res_total_q;
    res_span_d   = res_span_q;
    fdone        = 1'b0;
    froot        = root_q;
    win          = ra_q;
    lose         = rb_q;
    p_we_o       = 1'b0;
    p_waddr_o    = cur_q;
    p_wdata_o    = root_q;
    p_raddr_o    = cur_q;
    s_we_o       = 1'b0;
    s_waddr_o    = ra_q;
    s_wdata_o    = sa_q;
    s_raddr_o    = ra_q;

    unique case (state_q)
      ST_CLEAR: begin
        p_we_o    = 1'b1;
        p_waddr_o = clr_q;
        p_wdata_o = clr_q;
        s_we_o    = 1'b1;
        s_waddr_o = clr_q;
        s_wdata_o = SW'(1);
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (edge_i.valid) begin
          a_d      = NW'(edge_i.node_a);
          b_d      = NW'(edge_i.node_b);
          w_d      = edge_i.weight;
          merged_d = 1'b0;
          span_d   = 1'b0;
          if (a_ok) begin
            phase_d   = pair_ok ? PH_FIND_A : PH_SPAN;
            cur_d     = NW'(edge_i.node_a);
            start_d   = NW'(edge_i.node_a);
            p_raddr_o = NW'(edge_i.node_a);
            state_d   = ST_WALK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (p_rdata_i == cur_q) begin
          root_d = cur_q;
          if (start_q == cur_q) begin
            fdone = 1'b1;
            froot = cur_q;
          end else begin
            // Second pass: walk the path again and point every node at the root.
            cur_d     = start_q;
            p_raddr_o = start_q;
            state_d   = ST_COMP;
          end
        end else begin
          cur_d     = p_rdata_i;
          p_raddr_o = p_rdata_i;
        end
      end
      ST_COMP: begin
        p_we_o    = 1'b1;
        p_waddr_o = cur_q;
        p_wdata_o = root_q;
        if (p_rdata_i == root_q) begin
          fdone = 1'b1;
          froot = root_q;
        end else begin
          cur_d     = p_rdata_i;
          p_raddr_o = p_rdata_i;
        end
      end
      ST_SIZE_A: begin
        sa_d      = s_rdata_i;
        s_raddr_o = rb_q;
        state_d   = ST_SIZE_B;
      end
      ST_SIZE_B: begin
        // Equal sizes keep the first endpoint's root on top.
        if (sa_q < s_rdata_i) begin
          win  = rb_q;
          lose = ra_q;
        end else begin
          win  = ra_q;
          lose = rb_q;
        end
        p_we_o    = 1'b1;
        p_waddr_o = lose;
        p_wdata_o = win;
        s_we_o    = 1'b1;
        s_waddr_o = win;
        s_wdata_o = SW'(sa_q + s_rdata_i);
        merged_d  = 1'b1;
        total_d   = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
        phase_d   = PH_SPAN;
        cur_d     = a_q;
        start_d   = a_q;
        p_raddr_o = a_q;
        state_d   = ST_WALK;
      end
      ST_SPAN: begin
        span_d  = KW'(s_rdata_i) >= KW'(node_count_i);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid_q || result_o.ready) begin
          res_valid_d  = 1'b1;
          res_merged_d = merged_q;
          res_total_d  = total_q;
          res_span_d   = span_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fdone) begin
      unique case (phase_q)
        PH_FIND_A: begin
          ra_d      = froot;
          phase_d   = PH_FIND_B;
          cur_d     = b_q;
          start_d   = b_q;
          p_raddr_o = b_q;
          state_d   = ST_WALK;
        end
        PH_FIND_B: begin
          rb_d = froot;
          if (froot == ra_q) begin
            phase_d   = PH_SPAN;
            cur_d     = a_q;
            start_d   = a_q;
            p_raddr_o = a_q;
            state_d   = ST_WALK;
          end else begin
            s_raddr_o = ra_q;
            state_d   = ST_SIZE_A;
          end
        end
        default: begin
          s_raddr_o = froot;
          state_d   = ST_SPAN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      phase_q      <= PH_FIND_A;
      cur_q        <= '0;
      start_q      <= '0;
      root_q       <= '0;
      a_q          <= '0;
      b_q          <= '0;
      ra_q         <= '0;
      rb_q         <= '0;
      clr_q        <= '0;
      sa_q         <= '0;
      w_q          <= '0;
      total_q      <= '0;
      merged_q     <= 1'b0;
      span_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      res_merged_q <= 1'b0;
      res_total_q  <= '0;
      res_span_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      cur_q        <= cur_d;
      start_q      <= start_d;
      root_q       <= root_d;
      a_q          <= a_d;
      b_q          <= b_d;
      ra_q         <= ra_d;
      rb_q         <= rb_d;
      clr_q        <= clr_d;
      sa_q         <= sa_d;
      w_q          <= w_d;
      total_q      <= total_d;
      merged_q     <= merged_d;
      span_q       <= span_d;
      res_valid_q  <= res_valid_d;
      res_merged_q <= res_merged_d;
      res_total_q  <= res_total_d;
      res_span_q   <= res_span_d;
    end
  end

endmodule

/* hw/rtl/kruskal_union_find_merger_unit.sv */
// ----------------------------------------------------------------------------
// Kruskal union-find merger
// Takes edges, which the user must give in nondecreasing weight order (the
// block does not check it), and keeps a union-find forest in two on-chip
// RAMs, a parent table and a component size table, each with one write and
// one registered read port. Every edge gives one result: whether it joined
// two components, the saturating total of merging weights, and whether the
// first endpoint's component now holds at least node_count nodes. After
// reset the block clears every entry of both tables before it takes the
// first edge. An edge with node_a outside the forest goes straight to its
// result; one with node_b outside the forest or an endpoint at or above
// node_count runs only the spanning find; any other edge finds both
// endpoints, merges them if their roots differ, then runs the spanning find.
// Each parent link walked in a find lengthens the edge. A finished result
// sits in an output register, so the next edge is taken while it waits.
// node_count is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while the block idles; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module kruskal_union_find_merger_unit #(
  parameter int unsigned NODES = kufm_pkg::NODES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kufm_pkg::NC_W-1:0] cfg_wdata_i,
  kufm_edge_if.sink                 edge_i,
  kufm_result_if.source             result_o
);
  import kufm_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned SW = $clog2(NODES + 1);

  logic [NC_W-1:0] node_count_q;

  logic            p_we;
  logic [NW-1:0]   p_waddr;
  logic [NW-1:0]   p_wdata;
  logic [NW-1:0]   p_raddr;
  logic [NW-1:0]   p_rdata;
  logic            s_we;
  logic [NW-1:0]   s_waddr;
  logic [SW-1:0]   s_wdata;
  logic [NW-1:0]   s_raddr;
  logic [SW-1:0]   s_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NC_RESET;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  kufm_ram #(
    .DEPTH (NODES),
    .WIDTH (NW)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  kufm_ram #(
    .DEPTH (NODES),
    .WIDTH (SW)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  kufm_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .edge_i       (edge_i),
    .result_o     (result_o),
    .p_we_o       (p_we),
    .p_waddr_o    (p_waddr),
    .p_wdata_o    (p_wdata),
    .p_raddr_o    (p_raddr),
    .p_rdata_i    (p_rdata),
    .s_we_o       (s_we),
    .s_waddr_o    (s_waddr),
    .s_wdata_o    (s_wdata),
    .s_raddr_o    (s_raddr),
    .s_rdata_i    (s_rdata)
  );

endmodule

/* hw/rtl/kufm_checker.sv */
// ----------------------------------------------------------------------------
// Merger port checker
// Watches the top-level channels: result ordering against accepted items and
// the behaviour of the running total across delivered results.
// ----------------------------------------------------------------------------
module kufm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_merged_i,
  input logic                         out_spanning_i,
  input logic [kufm_pkg::TOTAL_W-1:0] out_total_i
);
  import kufm_pkg::*;

  logic [1:0]         pend_q;
  logic [TOTAL_W-1:0] last_q;
  logic               have_q;
  logic               in_acc;
  logic               out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      last_q <= '0;
      have_q <= 1'b0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        last_q <= out_total_i;
        have_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_total_i) &&
      $stable(out_merged_i) && $stable(out_spanning_i))
    else $error("result changed while stalled");

  // A result never appears without an item that caused it.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  // While ready for an item, at most one earlier result may still be waiting.
  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> pend_q <= 2'd1)
    else $error("item taken while more than one result outstanding");

  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_q |-> out_total_i >= last_q)
    else $error("total decreased");

  a_total_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_q && !out_merged_i |-> out_total_i == last_q)
    else $error("total moved on a non-merging edge");

endmodule

bind kruskal_union_find_merger_unit kufm_checker u_kufm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (edge_i.valid),
  .in_ready_i     (edge_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_merged_i   (result_o.merged),
  .out_spanning_i (result_o.spanning),
  .out_total_i    (result_o.total_weight)
);
